// ===== rtl/ctbg_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and register codes for the tilt bar graph
package ctbg_pkg;

	// sizes of the sample path and the state
	localparam int SAMPLE_W = 10;
	localparam int THR_W    = 8;
	localparam int CNT_W    = 6;
	localparam int SUM_W    = 16;
	localparam int REFC_W   = 9;
	localparam int BAR_W    = 3;

	// calibration length and refresh period
	localparam logic [CNT_W-1:0]  CAL_SAMPLES   = CNT_W'(50);
	localparam logic [REFC_W-1:0] REFRESH_LIMIT = REFC_W'(300);

	// mean by reciprocal multiply: exact for every 16-bit sum divided by CAL_SAMPLES
	localparam int MEAN_SHIFT = 22;
	localparam int MULT_W     = MEAN_SHIFT + 1;
	localparam int PROD_W     = SUM_W + MULT_W;
	localparam logic [MULT_W-1:0] MEAN_MULT =
		MULT_W'((64'd1 << MEAN_SHIFT) / CAL_SAMPLES + 64'd1);

	// threshold reset values
	localparam logic [THR_W-1:0] THR_ONE_RST   = THR_W'(25);
	localparam logic [THR_W-1:0] THR_TWO_RST   = THR_W'(50);
	localparam logic [THR_W-1:0] THR_THREE_RST = THR_W'(75);

	// register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_THR_ONE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_TWO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR_THREE = 2'd2;

	// thermometer codes of the bar
	localparam logic [BAR_W-1:0] BAR_OFF   = 3'b000;
	localparam logic [BAR_W-1:0] BAR_ONE   = 3'b001;
	localparam logic [BAR_W-1:0] BAR_TWO   = 3'b011;
	localparam logic [BAR_W-1:0] BAR_THREE = 3'b111;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                restart;
	} in_word_t;

	typedef struct packed {
		logic                calibrating;
		logic [SAMPLE_W-1:0] deviation;
		logic                direction_up;
		logic                refresh;
		logic [BAR_W-1:0]    up_leds;
		logic [BAR_W-1:0]    down_leds;
		logic [SAMPLE_W-1:0] reference;
	} out_word_t;

	typedef struct packed {
		logic [THR_W-1:0] one;
		logic [THR_W-1:0] two;
		logic [THR_W-1:0] three;
	} thr_t;

endpackage

// ===== rtl/ctbg_cfg_regs.sv =====
`timescale 1ns / 1ps
// threshold register file with a plain write port
module ctbg_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [ctbg_pkg::CFG_IDX_W-1:0]  index,
	input  logic [ctbg_pkg::THR_W-1:0]      data,
	output ctbg_pkg::thr_t                  thr
);
	import ctbg_pkg::*;

	thr_t thr_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.one   <= THR_ONE_RST;
			thr_q.two   <= THR_TWO_RST;
			thr_q.three <= THR_THREE_RST;
		end else if (we) begin
			case (index)
				REG_THR_ONE:   thr_q.one   <= data;
				REG_THR_TWO:   thr_q.two   <= data;
				REG_THR_THREE: thr_q.three <= data;
				default: ;
			endcase
		end
	end

	assign thr = thr_q;

endmodule

// ===== rtl/ctbg_core.sv =====
`timescale 1ns / 1ps
// calibration, deviation and bar state; result of one word per enable
module ctbg_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  ctbg_pkg::in_word_t  word,
	input  ctbg_pkg::thr_t      thr,
	output ctbg_pkg::out_word_t res
);
	import ctbg_pkg::*;

	logic                in_cal_q;
	logic [CNT_W-1:0]    cal_count_q;
	logic [SUM_W-1:0]    cal_sum_q;
	logic [SAMPLE_W-1:0] cal_mean_q;
	logic [REFC_W-1:0]   refresh_count_q;
	logic [BAR_W-1:0]    up_bar_q;
	logic [BAR_W-1:0]    down_bar_q;

	// state as seen after an optional restart
	logic                cur_cal;
	logic [CNT_W-1:0]    cur_count;
	logic [SUM_W-1:0]    cur_sum;
	logic [SAMPLE_W-1:0] cur_mean;
	logic [REFC_W-1:0]   cur_refc;
	logic [BAR_W-1:0]    cur_up;
	logic [BAR_W-1:0]    cur_down;

	// next state
	logic                nxt_cal;
	logic [CNT_W-1:0]    nxt_count;
	logic [SUM_W-1:0]    nxt_sum;
	logic [SAMPLE_W-1:0] nxt_mean;
	logic [REFC_W-1:0]   nxt_refc;
	logic [BAR_W-1:0]    nxt_up;
	logic [BAR_W-1:0]    nxt_down;

	logic [PROD_W-1:0]   prod;
	logic [SAMPLE_W-1:0] dev;
	logic                up;
	logic                do_refresh;
	logic [BAR_W-1:0]    code;

	// restart behaves as a reset of the state
	always_comb begin
		cur_cal   = word.restart ? 1'b1 : in_cal_q;
		cur_count = word.restart ? '0 : cal_count_q;
		cur_sum   = word.restart ? '0 : cal_sum_q;
		cur_mean  = word.restart ? '0 : cal_mean_q;
		cur_refc  = word.restart ? '0 : refresh_count_q;
		cur_up    = word.restart ? BAR_OFF : up_bar_q;
		cur_down  = word.restart ? BAR_OFF : down_bar_q;
	end

	// running sum and mean by reciprocal multiply
	assign nxt_sum   = cur_sum + SUM_W'(word.sample);
	assign nxt_count = cur_count + CNT_W'(1);
	assign prod      = PROD_W'(nxt_sum) * PROD_W'(MEAN_MULT);

	// deviation magnitude and direction
	always_comb begin
		if (word.sample >= cur_mean) begin
			dev = word.sample - cur_mean;
			up  = 1'b0;
		end else begin
			dev = cur_mean - word.sample;
			up  = 1'b1;
		end
	end

	// bar level, highest threshold first
	always_comb begin
		if (dev >= SAMPLE_W'(thr.three))    code = BAR_THREE;
		else if (dev >= SAMPLE_W'(thr.two)) code = BAR_TWO;
		else if (dev >= SAMPLE_W'(thr.one)) code = BAR_ONE;
		else                                code = BAR_OFF;
	end

	assign do_refresh = !cur_cal && (cur_refc >= REFRESH_LIMIT);

	// next state and result
	always_comb begin
		nxt_cal  = cur_cal;
		nxt_mean = cur_mean;
		nxt_refc = cur_refc;
		nxt_up   = cur_up;
		nxt_down = cur_down;
		if (cur_cal) begin
			if (nxt_count >= CAL_SAMPLES) begin
				nxt_mean = prod[MEAN_SHIFT +: SAMPLE_W];
				nxt_cal  = 1'b0;
			end
		end else if (do_refresh) begin
			nxt_refc = '0;
			nxt_up   = up ? code : BAR_OFF;
			nxt_down = up ? BAR_OFF : code;
		end else begin
			nxt_refc = cur_refc + REFC_W'(1);
		end

		res.calibrating  = cur_cal;
		res.deviation    = cur_cal ? '0 : dev;
		res.direction_up = cur_cal ? 1'b0 : up;
		res.refresh      = do_refresh;
		res.up_leds      = nxt_up;
		res.down_leds    = nxt_down;
		res.reference    = nxt_mean;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cal_q        <= 1'b1;
			cal_count_q     <= '0;
			cal_sum_q       <= '0;
			cal_mean_q      <= '0;
			refresh_count_q <= '0;
			up_bar_q        <= BAR_OFF;
			down_bar_q      <= BAR_OFF;
		end else if (en) begin
			in_cal_q        <= nxt_cal;
			cal_count_q     <= cur_cal ? nxt_count : cur_count;
			cal_sum_q       <= cur_cal ? nxt_sum : cur_sum;
			cal_mean_q      <= nxt_mean;
			refresh_count_q <= nxt_refc;
			up_bar_q        <= nxt_up;
			down_bar_q      <= nxt_down;
		end
	end

	// only one side of the graph is lit
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		(up_bar_q == BAR_OFF) || (down_bar_q == BAR_OFF))
		else $error("both bars lit");

	// bars hold between refreshes while measuring
	a_bar_hold: assert property (@(posedge clk) disable iff (!arst_n)
		en && !res.calibrating && !res.refresh |=>
		$stable(up_bar_q) && $stable(down_bar_q))
		else $error("bars changed without refresh");

	// a calibration word reports no deviation and no refresh
	a_cal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.calibrating |->
		(res.deviation == '0) && !res.direction_up && !res.refresh)
		else $error("calibration word carries measurement");

	// restart always puts the block back into calibration
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		en && word.restart |-> res.calibrating)
		else $error("restart did not calibrate");

endmodule

// ===== rtl/calibrated_tilt_bar_graph.sv =====
`timescale 1ns / 1ps
// Calibrated tilt bar graph: takes one sample word per clock, unless stalled, and returns
// one result word for each. Throughput is one word per cycle, sustained while the output
// side takes words. A word accepted into the input register moves on into the result
// register once that register is empty or being read, and its result is then valid there;
// while the output side holds off, the word waits in place.
// The core updates the calibration and refresh state once per word, as the word moves
// into the result register; the mean at the end of calibration comes from a 16-bit by
// 23-bit reciprocal multiply in that same step. There is no clearing pass after reset.
// A threshold write lands at once and is not held back, so write thresholds only while
// no word is in flight.
module calibrated_tilt_bar_graph (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ctbg_pkg::in_word_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ctbg_pkg::out_word_t            out_data,
	input  logic                           cfg_we,
	input  logic [ctbg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ctbg_pkg::THR_W-1:0]     cfg_data
);
	import ctbg_pkg::*;

	logic      valid_s1;
	in_word_t  word_s1;
	logic      valid_s2;
	out_word_t word_s2;
	logic      load_s2;
	logic      advance;
	thr_t      thr;
	out_word_t res;

	ctbg_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.thr    (thr)
	);

	ctbg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.word   (word_s1),
		.thr    (thr),
		.res    (res)
	);

	// flow control between input and result registers
	assign load_s2  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && load_s2;
	assign in_ready = !valid_s1 || load_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = word_s2;

	// a stalled result word stays in place
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word lost while stalled");

	// the input register never drops a word
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(word_s1))
		else $error("input word lost while stalled");

	// a word moves on only when the result register can take it
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced word missing from result register");

endmodule
